// ----- src/gpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Gray pattern pixel decoder package
// Shared widths, register indexes and the bundles that pass between the
// decoder's submodules.
// ----------------------------------------------------------------------------
package gpd_pkg;

  // Widest Gray code and the table that it addresses.
  localparam int CODE_BITS = 10;
  localparam int TBL_DEPTH = 1 << CODE_BITS;
  localparam int CNT_W     = 4;
  localparam int PIX_W     = 8;
  localparam int SIZE_W    = 16;
  localparam int COORD_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_HEIGHT = 2'd3;

  // Request kinds.
  localparam logic KIND_TABLE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [CNT_W-1:0]  num_bits;
    logic              vertical;
    logic [SIZE_W-1:0] projector_width;
    logic [SIZE_W-1:0] projector_height;
  } cfg_t;

  // Access to the stripe table.
  typedef struct packed {
    logic                 wr_en;
    logic [CODE_BITS-1:0] wr_addr;
    logic [CODE_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [CODE_BITS-1:0] rd_addr;
  } tbl_req_t;

  // A completed pixel on its way to scaling.
  typedef struct packed {
    logic                 load;
    logic [CODE_BITS-1:0] code;
    logic [SIZE_W-1:0]    period;
  } pixel_t;

  // Status of the scaling stage.
  typedef struct packed {
    logic slot_valid;
    logic slot_free;
  } scale_stat_t;

endpackage

// ----- src/gpd_in_if.sv -----
// ----------------------------------------------------------------------------
// Input request channel
// Carries table writes and bit-plane samples with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gpd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [gpd_pkg::CODE_BITS-1:0] table_index;
  logic [gpd_pkg::CODE_BITS-1:0] table_value;
  logic [gpd_pkg::PIX_W-1:0]     bright;
  logic [gpd_pkg::PIX_W-1:0]     dark;

  modport source (output valid, kind, table_index, table_value, bright, dark,
                  input ready);
  modport sink   (input valid, kind, table_index, table_value, bright, dark,
                  output ready);
endinterface

// ----- src/gpd_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Carries one decoded coordinate and its Gray code per pixel.
// ----------------------------------------------------------------------------
interface gpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [gpd_pkg::COORD_W-1:0]   coordinate;
  logic [gpd_pkg::CODE_BITS-1:0] gray_code;

  modport source (output valid, coordinate, gray_code, input ready);
  modport sink   (input valid, coordinate, gray_code, output ready);
endinterface

// ----- src/gpd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gpd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gpd_pkg::CFG_IDX_W-1:0] index;
  logic [gpd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/gpd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module gpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/gpd_collect.sv -----
// ----------------------------------------------------------------------------
// Gray pattern bit collector
// Gathers one bit per sample into the pixel's Gray code, issues the table
// lookup when the pixel completes and forwards table writes to the memory.
// ----------------------------------------------------------------------------
module gpd_collect (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              kind,
  input  logic [gpd_pkg::CODE_BITS-1:0]     table_index,
  input  logic [gpd_pkg::CODE_BITS-1:0]     table_value,
  input  logic [gpd_pkg::PIX_W-1:0]         bright,
  input  logic [gpd_pkg::PIX_W-1:0]         dark,
  input  gpd_pkg::cfg_t                     cfg,
  output gpd_pkg::tbl_req_t                 tbl_req,
  output gpd_pkg::pixel_t                   pixel,
  output logic [gpd_pkg::CNT_W-1:0]         bit_count_out
);

  logic [gpd_pkg::CODE_BITS-1:0] code_acc;
  logic [gpd_pkg::CODE_BITS-1:0] code_acc_next;
  logic [gpd_pkg::CNT_W-1:0]     bit_count;
  logic [gpd_pkg::CNT_W-1:0]     bit_count_next;
  logic [gpd_pkg::CNT_W-1:0]     eff_bits;
  logic [gpd_pkg::CODE_BITS-1:0] code_mask;
  logic [gpd_pkg::CODE_BITS-1:0] ones;
  logic [gpd_pkg::CODE_BITS-1:0] acc_upd;
  logic [gpd_pkg::CNT_W-1:0]     cnt_upd;
  logic [gpd_pkg::SIZE_W-1:0]    size_sel;
  logic                          bit_set;
  logic                          is_sample;
  logic                          done;

  // Effective bit count: zero counts as one, large values clamp.
  always_comb begin
    priority if (cfg.num_bits == '0) begin
      eff_bits = gpd_pkg::CNT_W'(1);
    end else if (cfg.num_bits > gpd_pkg::CNT_W'(gpd_pkg::CODE_BITS)) begin
      eff_bits = gpd_pkg::CNT_W'(gpd_pkg::CODE_BITS);
    end else begin
      eff_bits = cfg.num_bits;
    end
  end

  // Bit decision and the updated accumulator and count.
  assign is_sample = accept && (kind == gpd_pkg::KIND_SAMPLE);
  assign bit_set   = (bright > dark) &&
                     (bit_count < gpd_pkg::CNT_W'(gpd_pkg::CODE_BITS));
  assign acc_upd   = code_acc | (gpd_pkg::CODE_BITS'(bit_set) << bit_count);
  assign cnt_upd   = bit_count + gpd_pkg::CNT_W'(1);
  assign done      = cnt_upd >= eff_bits;
  assign ones      = '1;
  assign code_mask = ~(ones << eff_bits);
  assign size_sel  = cfg.vertical ? cfg.projector_width : cfg.projector_height;

  // Completed pixel and its table lookup.
  assign pixel.load   = is_sample && done;
  assign pixel.code   = acc_upd & code_mask;
  assign pixel.period = size_sel >> eff_bits;

  assign tbl_req.wr_en   = accept && (kind == gpd_pkg::KIND_TABLE);
  assign tbl_req.wr_addr = table_index;
  assign tbl_req.wr_data = table_value;
  assign tbl_req.rd_en   = pixel.load;
  assign tbl_req.rd_addr = pixel.code;

  // Next pixel state: a finished pixel starts over.
  always_comb begin
    code_acc_next  = code_acc;
    bit_count_next = bit_count;
    if (is_sample) begin
      if (done) begin
        code_acc_next  = '0;
        bit_count_next = '0;
      end else begin
        code_acc_next  = acc_upd;
        bit_count_next = cnt_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_acc  <= '0;
      bit_count <= '0;
    end else begin
      code_acc  <= code_acc_next;
      bit_count <= bit_count_next;
    end
  end

  assign bit_count_out = bit_count;

endmodule

// ----- src/gpd_scale.sv -----
// ----------------------------------------------------------------------------
// Gray pattern coordinate scaler
// Holds a looked-up pixel while its stripe arrives from the table, multiplies
// the stripe by the period and keeps the result in the output register.
// ----------------------------------------------------------------------------
module gpd_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  gpd_pkg::pixel_t                   pixel,
  input  logic [gpd_pkg::CODE_BITS-1:0]     stripe,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [gpd_pkg::COORD_W-1:0]       coordinate,
  output logic [gpd_pkg::CODE_BITS-1:0]     gray_code,
  output gpd_pkg::scale_stat_t              stat
);

  localparam int PROD_W = gpd_pkg::CODE_BITS + gpd_pkg::SIZE_W;

  logic                          slot_valid;
  logic [gpd_pkg::CODE_BITS-1:0] slot_code;
  logic [gpd_pkg::SIZE_W-1:0]    slot_period;
  logic [PROD_W-1:0]             product;
  logic                          advance;

  // The output register moves when it is empty or being drained.
  assign advance        = !out_valid || out_ready;
  assign stat.slot_valid = slot_valid;
  assign stat.slot_free  = !slot_valid || advance;

  // Lookup slot: holds the pixel while its table read data arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (pixel.load) begin
      slot_valid <= 1'b1;
    end else if (advance) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.load) begin
      slot_code   <= pixel.code;
      slot_period <= pixel.period;
    end
  end

  // Stripe times period; the low bits form the coordinate.
  assign product = PROD_W'(stripe) * PROD_W'(slot_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= slot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && slot_valid) begin
      coordinate <= product[gpd_pkg::COORD_W-1:0];
      gray_code  <= slot_code;
    end
  end

endmodule

// ----- src/gray_pattern_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// Gray pattern pixel decoder
// Decodes one camera pixel's structured-light Gray code into a projector
// coordinate through a stripe lookup table.
// ----------------------------------------------------------------------------
// Usage:
//   samples carries table writes (kind 0: table_index, table_value) and
//   bit-plane samples (kind 1: bright, dark). A sample sets the next Gray
//   bit, least significant first, when bright exceeds dark. After num_bits
//   samples the code is looked up in the stripe table and scaled by the
//   period, projector width or height shifted right by num_bits.
//   results carries coordinate and gray_code, one result per pixel.
//   cfg writes num_bits, vertical, projector_width, projector_height by
//   index 0 to 3; it is always ready and must be used only while idle.
//   Throughput is one request per cycle on samples while samples is ready. A
//   result passes from its last sample through the table memory read into
//   the lookup slot, then through the multiply into the output register.
//   While results is stalled one more completed pixel waits in the lookup
//   slot; samples then stays ready for table writes and samples that do not
//   complete a pixel only until that slot fills, after which it holds off.
//   Reset clears the pixel in progress, the pipeline and the registers to
//   their defaults. The table holds no defined value until written.
// ----------------------------------------------------------------------------
module gray_pattern_pixel_decoder (
  input  logic     clk,
  input  logic     rst,
  gpd_cfg_if.sink  cfg,
  gpd_in_if.sink   samples,
  gpd_out_if.source results
);

  gpd_pkg::cfg_t        cfg_regs;
  gpd_pkg::tbl_req_t    tbl_req;
  gpd_pkg::pixel_t      pixel;
  gpd_pkg::scale_stat_t scale_stat;
  logic [gpd_pkg::CODE_BITS-1:0] stripe;
  logic [gpd_pkg::CNT_W-1:0]     bit_count;
  logic                          accept;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.num_bits         <= gpd_pkg::CNT_W'(10);
      cfg_regs.vertical         <= 1'b1;
      cfg_regs.projector_width  <= gpd_pkg::SIZE_W'(1024);
      cfg_regs.projector_height <= gpd_pkg::SIZE_W'(768);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        gpd_pkg::REG_NUM_BITS:    cfg_regs.num_bits <= cfg.data[gpd_pkg::CNT_W-1:0];
        gpd_pkg::REG_VERTICAL:    cfg_regs.vertical <= cfg.data[0];
        gpd_pkg::REG_PROJ_WIDTH:  cfg_regs.projector_width <= cfg.data;
        gpd_pkg::REG_PROJ_HEIGHT: cfg_regs.projector_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input handshake.
  assign samples.ready = scale_stat.slot_free;
  assign accept        = samples.valid && samples.ready;

  gpd_collect u_collect (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind         (samples.kind),
    .table_index  (samples.table_index),
    .table_value  (samples.table_value),
    .bright       (samples.bright),
    .dark         (samples.dark),
    .cfg          (cfg_regs),
    .tbl_req      (tbl_req),
    .pixel        (pixel),
    .bit_count_out(bit_count)
  );

  // Stripe lookup table.
  gpd_ram #(
    .WIDTH(gpd_pkg::CODE_BITS),
    .DEPTH(gpd_pkg::TBL_DEPTH)
  ) u_stripe_ram (
    .clk    (clk),
    .wr_en  (tbl_req.wr_en),
    .wr_addr(tbl_req.wr_addr),
    .wr_data(tbl_req.wr_data),
    .rd_en  (tbl_req.rd_en),
    .rd_addr(tbl_req.rd_addr),
    .rd_data(stripe)
  );

  gpd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .stripe    (stripe),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .coordinate(results.coordinate),
    .gray_code (results.gray_code),
    .stat      (scale_stat)
  );

  // The bit counter never runs past the widest code.
  assert property (@(posedge clk) disable iff (rst)
    bit_count <= gpd_pkg::CNT_W'(gpd_pkg::CODE_BITS))
    else $error("bit counter beyond code width");

  // A completed pixel always lands in the lookup slot.
  assert property (@(posedge clk) disable iff (rst)
    pixel.load |=> scale_stat.slot_valid)
    else $error("completed pixel lost");

  // A full slot behind a stalled output blocks new requests.
  assert property (@(posedge clk) disable iff (rst)
    (scale_stat.slot_valid && results.valid && !results.ready) |-> !samples.ready)
    else $error("request taken while pipeline is full");

  // No result straight out of reset.
  assert property (@(posedge clk) $past(rst) |-> !results.valid)
    else $error("result valid after reset");

endmodule
